/* hw/rtl/iq_dc_block_scale_decimate_macros.svh */
// Assertion macros for the I/Q DC blocker, scaler and decimator.
`ifndef IQ_DC_BLOCK_SCALE_DECIMATE_MACROS_SVH
`define IQ_DC_BLOCK_SCALE_DECIMATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IQDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iqdc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IQDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iqdc assertion failed");

`endif

/* hw/rtl/iqdc_pkg.sv */
// Package with types, constants and datapath functions of the I/Q conditioner.
`timescale 1ns / 1ps

package iqdc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int GAIN_W      = 4;
  localparam int MAX_GAIN    = (1 << GAIN_W) - 1;
  localparam int WIDE_W      = DIFF_W + MAX_GAIN;
  localparam int DCS_W       = 5;
  localparam int RATE_W      = 26;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic [DCS_W-1:0]              dcs_t;
  typedef logic [RATE_W-1:0]             rate_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_DC_EN    = 3'd0;
  localparam cfg_idx_t REG_DC_SHIFT = 3'd1;
  localparam cfg_idx_t REG_GAIN     = 3'd2;
  localparam cfg_idx_t REG_TGT_RATE = 3'd3;
  localparam cfg_idx_t REG_IN_RATE  = 3'd4;

  // Reset values of the registers.
  localparam logic  RST_DC_EN    = 1'b1;
  localparam dcs_t  RST_DC_SHIFT = 5'd12;
  localparam gain_t RST_GAIN     = 4'd4;
  localparam rate_t RST_TGT_RATE = 26'd1000000;
  localparam rate_t RST_IN_RATE  = 26'd2500000;

  localparam dcs_t DC_SHIFT_MIN = 5'd1;
  localparam dcs_t DC_SHIFT_MAX = 5'd20;

  localparam samp_t SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam samp_t SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    samp_t est;
    diff_t diff;
  } dc_res_t;

  function automatic dcs_t clamp_dc_shift(dcs_t s);
    if (s < DC_SHIFT_MIN) begin
      return DC_SHIFT_MIN;
    end else if (s > DC_SHIFT_MAX) begin
      return DC_SHIFT_MAX;
    end
    return s;
  endfunction

  // Move the estimate toward the sample by the floored, shifted difference,
  // then subtract the new estimate from the sample.
  function automatic dc_res_t dc_remove(samp_t x, samp_t est, dcs_t s);
    diff_t   d;
    diff_t   step;
    diff_t   est_new;
    dc_res_t r;
    d       = diff_t'(x) - diff_t'(est);
    step    = d >>> s;
    est_new = diff_t'(est) + step;
    r.est   = est_new[SAMPLE_BITS-1:0];
    r.diff  = diff_t'(x) - diff_t'(r.est);
    return r;
  endfunction

  // Shift left into a wide word and saturate back to a sample.
  function automatic samp_t scale_sat(diff_t v, gain_t g);
    wide_t w;
    w = wide_t'(v) <<< g;
    if (w[WIDE_W-1:SAMPLE_BITS-1] == {(WIDE_W-SAMPLE_BITS+1){1'b0}} ||
        w[WIDE_W-1:SAMPLE_BITS-1] == {(WIDE_W-SAMPLE_BITS+1){1'b1}}) begin
      return w[SAMPLE_BITS-1:0];
    end
    return w[WIDE_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

endpackage

/* hw/rtl/iqdc_in_if.sv */
// Stream interface that carries raw I/Q sample words into the block.
`timescale 1ns / 1ps

interface iqdc_in_if;
  logic                  valid;
  logic                  ready;
  iqdc_pkg::samp_t       raw_i;
  iqdc_pkg::samp_t       raw_q;

  modport source (output valid, output raw_i, output raw_q, input ready);
  modport sink   (input valid, input raw_i, input raw_q, output ready);
endinterface

/* hw/rtl/iqdc_out_if.sv */
// Stream interface that carries conditioned I/Q sample words out of the block.
`timescale 1ns / 1ps

interface iqdc_out_if;
  logic                  valid;
  logic                  ready;
  iqdc_pkg::samp_t       i_sample;
  iqdc_pkg::samp_t       q_sample;

  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

/* hw/rtl/iq_dc_block_scale_decimate.sv */
// Top level of the I/Q DC blocker, gain shifter and fractional decimator.
//
// Usage: raw I/Q sample words enter on in_ch (valid/ready) and conditioned
// words leave on out_ch (valid/ready). Each word may lose its DC part, is
// shifted left by the gain setting and saturated, and is then kept or dropped
// by the rate phase accumulator, so an input word gives zero or one output.
// Registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high, and writes are meant to happen while the block is idle.
// Data path: a word taken into the input register is computed from it and,
// once the output register is free or emptying, lands in the output register
// if the decimator keeps it, which then shows its result.
// Throughput: one word per cycle while out_ch.ready holds high. The DC estimate
// update (subtract, shift, add) is a feedback loop through the estimate registers and sets that figure.
// Reset: synchronous, active low; registers return to their default values,
// the DC estimates and the rate phase clear to zero, and both stages empty.
// Stall: while out_ch.ready is low the output register holds its word; the
// input register still takes one more word, and in_ch.ready drops after that
// until the output is taken.
`timescale 1ns / 1ps
`include "iq_dc_block_scale_decimate_macros.svh"

module iq_dc_block_scale_decimate (
  input  logic                       clk,
  input  logic                       rst_n,
  iqdc_in_if.sink                    in_ch,
  iqdc_out_if.source                 out_ch,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  iqdc_pkg::cfg_idx_t         cfg_index,
  input  iqdc_pkg::rate_t            cfg_data
);

  // Configuration registers.
  logic                dc_en_r;
  iqdc_pkg::dcs_t      dc_shift_r;
  iqdc_pkg::gain_t     gain_r;
  iqdc_pkg::rate_t     tgt_rate_r;
  iqdc_pkg::rate_t     in_rate_r;

  // Filter and rate state.
  iqdc_pkg::samp_t     est_i_r, est_i_nxt;
  iqdc_pkg::samp_t     est_q_r, est_q_nxt;
  iqdc_pkg::rate_t     phase_r, phase_nxt;

  // Input register.
  logic                s1_valid_r;
  iqdc_pkg::samp_t     s1_i_r, s1_q_r;

  // Output register.
  logic                out_valid_r;
  iqdc_pkg::samp_t     out_i_r, out_i_nxt;
  iqdc_pkg::samp_t     out_q_r, out_q_nxt;

  logic                in_acc;
  logic                s1_adv;
  logic                decim_on;
  logic                send;
  iqdc_pkg::dcs_t      dcs;
  iqdc_pkg::dc_res_t   res_i, res_q;
  iqdc_pkg::diff_t     diff_i, diff_q;
  logic [iqdc_pkg::RATE_W:0] phase_sum, phase_sub;
  logic                phase_wrap;

  assign cfg_ready = 1'b1;

  // The input word moves on whenever the output register is free or emptying.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.i_sample = out_i_r;
  assign out_ch.q_sample = out_q_r;

  // DC removal; with blocking off the sample passes unchanged.
  always_comb begin
    dcs   = iqdc_pkg::clamp_dc_shift(dc_shift_r);
    res_i = iqdc_pkg::dc_remove(s1_i_r, est_i_r, dcs);
    res_q = iqdc_pkg::dc_remove(s1_q_r, est_q_r, dcs);
    if (dc_en_r) begin
      diff_i    = res_i.diff;
      diff_q    = res_q.diff;
      est_i_nxt = res_i.est;
      est_q_nxt = res_q.est;
    end else begin
      diff_i    = iqdc_pkg::diff_t'(s1_i_r);
      diff_q    = iqdc_pkg::diff_t'(s1_q_r);
      est_i_nxt = est_i_r;
      est_q_nxt = est_q_r;
    end
    out_i_nxt = iqdc_pkg::scale_sat(diff_i, gain_r);
    out_q_nxt = iqdc_pkg::scale_sat(diff_q, gain_r);
  end

  // Fractional decimation: keep a word when the phase reaches in_rate; keep all words when off.
  always_comb begin
    decim_on   = (tgt_rate_r != '0) && (in_rate_r != '0) && (tgt_rate_r < in_rate_r);
    phase_sum  = {1'b0, phase_r} + {1'b0, tgt_rate_r};
    phase_sub  = phase_sum - {1'b0, in_rate_r};
    phase_wrap = phase_sum >= {1'b0, in_rate_r};
    if (!decim_on) begin
      phase_nxt = phase_r;
    end else if (phase_wrap) begin
      phase_nxt = phase_sub[iqdc_pkg::RATE_W-1:0];
    end else begin
      phase_nxt = phase_sum[iqdc_pkg::RATE_W-1:0];
    end
    send = !decim_on || phase_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_en_r    <= iqdc_pkg::RST_DC_EN;
      dc_shift_r <= iqdc_pkg::RST_DC_SHIFT;
      gain_r     <= iqdc_pkg::RST_GAIN;
      tgt_rate_r <= iqdc_pkg::RST_TGT_RATE;
      in_rate_r  <= iqdc_pkg::RST_IN_RATE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        iqdc_pkg::REG_DC_EN:    dc_en_r    <= cfg_data[0];
        iqdc_pkg::REG_DC_SHIFT: dc_shift_r <= cfg_data[iqdc_pkg::DCS_W-1:0];
        iqdc_pkg::REG_GAIN:     gain_r     <= cfg_data[iqdc_pkg::GAIN_W-1:0];
        iqdc_pkg::REG_TGT_RATE: tgt_rate_r <= cfg_data;
        iqdc_pkg::REG_IN_RATE:  in_rate_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_i_r     <= '0;
      est_q_r     <= '0;
      phase_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        est_i_r <= est_i_nxt;
        est_q_r <= est_q_nxt;
        phase_r <= phase_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && send) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_i_r <= in_ch.raw_i;
      s1_q_r <= in_ch.raw_q;
    end
    if (s1_adv && send) begin
      out_i_r <= out_i_nxt;
      out_q_r <= out_q_nxt;
    end
  end

  // Without decimation every word that leaves the input register is shown.
  `IQDC_ASSERT_NEXT(a_pass_all, clk, rst_n, s1_adv && !decim_on, out_valid_r)
  // The estimates only move when a word is processed with blocking on.
  `IQDC_ASSERT_NEXT(a_est_hold, clk, rst_n, !(s1_adv && dc_en_r),
                    $stable(est_i_r) && $stable(est_q_r))
  // The rate phase only moves when a word is processed with decimation on.
  `IQDC_ASSERT_NEXT(a_phase_hold, clk, rst_n, !(s1_adv && decim_on), $stable(phase_r))
  // A full input register with a stalled output blocks new words.
  `IQDC_ASSERT_SAME(a_back_press, clk, rst_n, s1_valid_r && out_valid_r && !out_ch.ready,
                    !in_ch.ready)

endmodule

/* dv/tb_iq_dc_block_scale_decimate.sv */
// Self-checking testbench for the I/Q DC blocker, gain shifter and decimator.
`timescale 1ns / 1ps

module tb_iq_dc_block_scale_decimate;
  import iqdc_pkg::*;

  // Timing and run length. The cycle limit covers several times the slowest
  // legal run: every word waiting out a full source gap and a full sink stall.
  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RAND_WORDS    = 800;
  localparam int CALM_WORDS    = 100;
  // A dropped word can still sit in the input register after the last
  // expected word arrives, so the drain waits longer before a register write.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int DIR_LEN       = 38;

  localparam rate_t    RATE_MAX  = '1;
  // An index with no register behind it; writes to it must change nothing.
  localparam cfg_idx_t REG_SPARE = 3'd7;

  typedef struct packed {
    samp_t i;
    samp_t q;
  } iq_word_t;

  // Directed rows: a plain word checked by the predictor, a word whose output
  // is typed into the table, or a register write.
  typedef enum logic [1:0] {ROW_WORD, ROW_CHECKED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_idx_t  idx;
    rate_t     val;
    samp_t     ri;
    samp_t     rq;
    samp_t     ei;
    samp_t     eq;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  rate_t    cfg_data;
  logic     sink_ready = 1'b0;

  iqdc_in_if  in_ch ();
  iqdc_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  iq_dc_block_scale_decimate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the registers and of the block state, kept by the predictor.
  logic  sh_dc_en;
  dcs_t  sh_dcs;
  gain_t sh_gain;
  rate_t sh_tgt_rate;
  rate_t sh_in_rate;
  samp_t est_i;
  samp_t est_q;
  rate_t phase;

  iq_word_t expected_words[$];
  dir_row_t dir_rows [DIR_LEN];
  int       err_count = 0;
  int       cycle_count;
  int       stall_left = 0;
  // Once set, neither side starts another idle burst.
  bit       calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: ends the run if the stimulus or the drain never finishes.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
      @(posedge clk);
    end
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // Leaky DC tracker: the estimate moves toward the sample by the floored,
  // shifted difference, and the new estimate is taken off the sample.
  function automatic longint strip_dc(inout samp_t est, input samp_t x,
                                      input int unsigned sh);
    longint d;
    d   = longint'(x) - longint'(est);
    est = samp_t'(longint'(est) + (d >>> sh));
    return longint'(x) - longint'(est);
  endfunction

  function automatic samp_t gain_clip(longint v, gain_t g);
    longint y;
    y = v <<< g;
    if (y > longint'(SAT_MAX)) begin
      return SAT_MAX;
    end
    if (y < longint'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return samp_t'(y);
  endfunction

  // Runs one accepted word through the predictor. Returns 1 when the
  // decimator keeps the word, with the conditioned word in w.
  function automatic bit condition_word(samp_t ri, samp_t rq, output iq_word_t w);
    longint          di;
    longint          dq;
    int unsigned     sh;
    logic [RATE_W:0] sum;
    bit              keep;
    di   = longint'(ri);
    dq   = longint'(rq);
    keep = 1'b1;
    if (sh_dc_en) begin
      sh = sh_dcs;
      if (sh_dcs < DC_SHIFT_MIN) begin
        sh = DC_SHIFT_MIN;
      end else if (sh_dcs > DC_SHIFT_MAX) begin
        sh = DC_SHIFT_MAX;
      end
      di = strip_dc(est_i, ri, sh);
      dq = strip_dc(est_q, rq, sh);
    end
    if (sh_tgt_rate != '0 && sh_in_rate != '0 && sh_tgt_rate < sh_in_rate) begin
      sum = {1'b0, phase} + {1'b0, sh_tgt_rate};
      if (sum >= {1'b0, sh_in_rate}) begin
        sum   = sum - {1'b0, sh_in_rate};
        phase = sum[RATE_W-1:0];
      end else begin
        phase = sum[RATE_W-1:0];
        keep  = 1'b0;
      end
    end
    w.i = gain_clip(di, sh_gain);
    w.q = gain_clip(dq, sh_gain);
    return keep;
  endfunction

  function automatic dir_row_t word_row(samp_t ri, samp_t rq);
    return '{ROW_WORD, REG_DC_EN, '0, ri, rq, '0, '0};
  endfunction

  function automatic dir_row_t checked_row(samp_t ri, samp_t rq, samp_t ei, samp_t eq);
    return '{ROW_CHECKED, REG_DC_EN, '0, ri, rq, ei, eq};
  endfunction

  function automatic dir_row_t reg_row(cfg_idx_t idx, rate_t val);
    return '{ROW_REG, idx, val, '0, '0, '0, '0};
  endfunction

  function automatic samp_t pick_edge();
    case ($urandom_range(0, 4))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return samp_t'(0);
      3: return samp_t'(-1);
      default: return samp_t'(1);
    endcase
  endfunction

  // Writes one register and mirrors it into the shadow copy once accepted.
  task automatic write_reg(cfg_idx_t idx, rate_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_DC_EN:    sh_dc_en    = val[0];
      REG_DC_SHIFT: sh_dcs      = val[DCS_W-1:0];
      REG_GAIN:     sh_gain     = val[GAIN_W-1:0];
      REG_TGT_RATE: sh_tgt_rate = val;
      REG_IN_RATE:  sh_in_rate  = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one input word, optionally after an idle burst, and returns at the
  // edge that accepted it with valid still high. A typed expectation, when
  // given, replaces the predicted word but the predictor state still moves.
  task automatic push_word(samp_t ri, samp_t rq, bit typed, iq_word_t typed_w);
    iq_word_t w;
    bit       keep;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_i <= ri;
    in_ch.raw_q <= rq;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    keep = condition_word(ri, rq, w);
    if (typed) begin
      keep = 1'b1;
      w    = typed_w;
    end
    if (keep) begin
      expected_words.push_back(w);
    end
  endtask

  // Stops the source and waits until the block has nothing left in flight.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sink side: checks every accepted output word against the oldest
  // expectation, and throttles ready in random stall bursts.
  always @(posedge clk) begin
    iq_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("output word %0d/%0d with nothing expected",
                                    out_ch.i_sample, out_ch.q_sample));
        end else begin
          want = expected_words.pop_front();
          if (out_ch.i_sample !== want.i) begin
            report_mismatch($sformatf("i_sample got %0d want %0d", out_ch.i_sample, want.i));
          end
          if (out_ch.q_sample !== want.q) begin
            report_mismatch($sformatf("q_sample got %0d want %0d", out_ch.q_sample, want.q));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        sink_ready <= (stall_left == 1);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 13);
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, the directed table, then random phases of register
  // settings followed by bursts of words.
  initial begin
    iq_word_t  typed_w;
    samp_t     ri;
    samp_t     rq;
    samp_t     offset_i;
    samp_t     offset_q;
    rate_t     in_r;
    rate_t     tgt_r;
    dcs_t      dcs_pick;
    gain_t     gain_pick;
    int        rand_words;
    int        burst;
    int        pick;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.raw_i <= '0;
    in_ch.raw_q <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_DC_EN;
    cfg_data    <= '0;

    sh_dc_en    = RST_DC_EN;
    sh_dcs      = RST_DC_SHIFT;
    sh_gain     = RST_GAIN;
    sh_tgt_rate = RST_TGT_RATE;
    sh_in_rate  = RST_IN_RATE;
    est_i       = '0;
    est_q       = '0;
    phase       = '0;
    rand_words  = 0;

    // The opening rows run on the reset settings, so the decimator keeps one
    // word in 2.5. Then decimation goes off and DC blocking is bypassed to
    // check plain saturation at both gain extremes. The estimates are then
    // driven far apart with the shortest time constant (a shift of 0 acts as
    // 1), and a sample of the opposite sign with a shift of 31 (acts as 20)
    // gives a difference beyond 16 bits that must saturate at zero gain.
    // The last rows walk the rate corners: equal rates, the widest ratio
    // just below one, and a tiny in_rate with the phase still large.
    dir_rows = '{
      word_row(100, -100),
      word_row(0, 0),
      word_row(0, 0),
      reg_row(REG_IN_RATE, 0),
      reg_row(REG_SPARE, RATE_MAX),
      reg_row(REG_DC_EN, 0),
      reg_row(REG_GAIN, 0),
      checked_row(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN),
      checked_row(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX),
      reg_row(REG_GAIN, 15),
      checked_row(1, -1, SAT_MAX, SAT_MIN),
      checked_row(0, 0, 0, 0),
      reg_row(REG_GAIN, 0),
      reg_row(REG_DC_EN, 1),
      reg_row(REG_DC_SHIFT, 0),
      word_row(SAT_MAX, SAT_MIN),
      word_row(SAT_MAX, SAT_MIN),
      word_row(SAT_MAX, SAT_MIN),
      word_row(SAT_MAX, SAT_MIN),
      word_row(SAT_MAX, SAT_MIN),
      reg_row(REG_DC_SHIFT, 31),
      checked_row(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX),
      reg_row(REG_GAIN, 3),
      reg_row(REG_DC_SHIFT, 5),
      word_row(1234, -4321),
      reg_row(REG_IN_RATE, RATE_MAX),
      reg_row(REG_TGT_RATE, RATE_MAX),
      word_row(-1, 1),
      reg_row(REG_TGT_RATE, RATE_MAX - 1),
      word_row(21845, -21846),
      word_row(-21846, 21845),
      word_row(0, 0),
      reg_row(REG_IN_RATE, 3),
      reg_row(REG_TGT_RATE, 1),
      word_row(7, -7),
      word_row(-7, 7),
      reg_row(REG_TGT_RATE, 0),
      word_row(300, -300)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_REG) begin
        drain_block();
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        typed_w.i = dir_rows[r].ei;
        typed_w.q = dir_rows[r].eq;
        push_word(dir_rows[r].ri, dir_rows[r].rq, dir_rows[r].kind == ROW_CHECKED, typed_w);
      end
    end

    // Random phases. Each one rewrites every register while the block is
    // idle, then streams a burst of words: half with a DC offset and noise so
    // the estimate settles, some fully random words and some extremes.
    while (rand_words < RAND_WORDS) begin
      drain_block();

      case ($urandom_range(0, 4))
        0: dcs_pick = '0;
        1: dcs_pick = DC_SHIFT_MIN;
        2: dcs_pick = DC_SHIFT_MAX;
        3: dcs_pick = '1;
        default: dcs_pick = dcs_t'($urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 3))
        0: gain_pick = '0;
        1: gain_pick = '1;
        default: gain_pick = gain_t'($urandom_range(0, 15));
      endcase
      // Rate modes: either rate zero, the target rate at or above in_rate,
      // the widest rates, or a plain ratio between one and one fifth.
      case ($urandom_range(0, 5))
        0: begin
          in_r  = '0;
          tgt_r = rate_t'($urandom_range(0, RATE_MAX));
        end
        1: begin
          in_r  = rate_t'($urandom_range(1, RATE_MAX));
          tgt_r = '0;
        end
        2: begin
          in_r  = rate_t'($urandom_range(1, RATE_MAX));
          tgt_r = rate_t'($urandom_range(in_r, RATE_MAX));
        end
        3: begin
          in_r  = RATE_MAX;
          tgt_r = RATE_MAX - rate_t'($urandom_range(1, 3));
        end
        default: begin
          in_r  = rate_t'($urandom_range(2, RATE_MAX));
          tgt_r = in_r / rate_t'($urandom_range(1, 5));
          if (tgt_r == '0) begin
            tgt_r = rate_t'(1);
          end
          if (tgt_r >= in_r) begin
            tgt_r = in_r - rate_t'(1);
          end
        end
      endcase

      write_reg(REG_DC_EN, rate_t'($urandom_range(0, 3) != 0));
      write_reg(REG_DC_SHIFT, rate_t'(dcs_pick));
      write_reg(REG_GAIN, rate_t'(gain_pick));
      write_reg(REG_TGT_RATE, tgt_r);
      write_reg(REG_IN_RATE, in_r);
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_SPARE, rate_t'($urandom_range(0, RATE_MAX)));
      end

      offset_i = samp_t'($urandom);
      offset_q = samp_t'($urandom);
      burst    = $urandom_range(20, 120);
      for (int k = 0; k < burst && rand_words < RAND_WORDS; k++) begin
        calm = (rand_words >= RAND_WORDS - CALM_WORDS);
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          ri = samp_t'(int'(offset_i) + int'($urandom_range(0, 511)) - 256);
          rq = samp_t'(int'(offset_q) + int'($urandom_range(0, 511)) - 256);
        end else if (pick < 8) begin
          ri = samp_t'($urandom);
          rq = samp_t'($urandom);
        end else begin
          ri = pick_edge();
          rq = pick_edge();
        end
        push_word(ri, rq, 1'b0, '0);
        rand_words++;
      end
    end

    // Let every expected word come out, then watch a little longer for
    // stray output words.
    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
